/* rtl/omsd_pkg.sv */
// Shared types, constants and helper functions for the orientational MSD correlator.
package omsd_pkg;

  localparam int unsigned MAX_LAGS_DEF      = 64;
  localparam int unsigned MAX_PARTICLES_DEF = 256;
  localparam int unsigned LAG_COUNT_RST     = 50;
  localparam int unsigned PART_COUNT_RST    = 256;
  localparam int unsigned CFG_W             = 9;
  localparam int unsigned LAG_PORT_W        = 6;
  localparam int unsigned DRAIN_CYCLES      = 10;

  localparam logic signed [63:0] ONE_Q28 = 64'sd1 <<< 28;
  localparam logic [62:0]        USAT    = '1;

  // register indexes
  localparam logic REG_LAG_COUNT  = 1'b0;
  localparam logic REG_PART_COUNT = 1'b1;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } orient_t;

  typedef struct packed {
    pos_t    pos;
    orient_t ori;
  } hist_t;

  typedef struct packed {
    logic        [62:0] par;
    logic        [62:0] perp;
    logic signed [63:0] l1;
    logic signed [63:0] l2;
  } acc_t;

  typedef struct packed {
    logic        [63:0] par;
    logic        [63:0] perp;
    logic signed [63:0] c;
    logic signed [63:0] p2;
  } term_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_READ
  } omsd_state_e;

  function automatic logic [62:0] uadd_sat(input logic [62:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s[64:63] != 2'b00) ? USAT : s[62:0];
  endfunction

  function automatic logic signed [63:0] sadd_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

/* rtl/omsd_hist_mem.sv */
// Per-particle sample history ring storage, one write and one registered read port.
module omsd_hist_mem import omsd_pkg::*; #(
  parameter int unsigned DEPTH = MAX_LAGS_DEF * MAX_PARTICLES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  hist_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output hist_t         rdata_o
);

  hist_t mem [DEPTH];
  hist_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/omsd_lag_math.sv */
// Pipelined arithmetic for one lag: displacement split, cosine and Legendre terms.
module omsd_lag_math import omsd_pkg::*; #(
  parameter int unsigned LAG_AW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  input  logic [LAG_AW-1:0] in_lag_i,
  input  hist_t             old_i,
  input  pos_t              new_pos_i,
  input  orient_t           new_ori_i,
  output logic              term_vld_o,
  output logic [LAG_AW-1:0] term_lag_o,
  output term_t             term_o
);

  localparam int unsigned NSTG = 7;

  logic              vld_q [NSTG];
  logic [LAG_AW-1:0] lag_q [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= in_vld_i;
      for (int i = 1; i < NSTG; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    lag_q[0] <= in_lag_i;
    for (int i = 1; i < NSTG; i++) lag_q[i] <= lag_q[i-1];
  end

  // A: displacement old - new
  logic signed [24:0] a_dx_q, a_dy_q, a_dz_q;
  orient_t            a_uo_q;
  // B: products
  logic signed [40:0] b_lx_q, b_ly_q, b_lz_q;
  logic signed [31:0] b_cx_q, b_cy_q, b_cz_q;
  logic signed [24:0] b_dx_q, b_dy_q, b_dz_q;
  // C: projection and cosine
  logic signed [42:0] c_l;
  logic signed [28:0] c_lr_q;
  logic signed [33:0] c_c_q;
  logic signed [24:0] c_dx_q, c_dy_q, c_dz_q;
  // D: second multiplies
  logic signed [44:0] d_ox_q, d_oy_q, d_oz_q;
  logic signed [57:0] d_par_q;
  logic signed [63:0] d_cc_q;
  logic signed [33:0] d_c_q;
  logic signed [24:0] d_dx_q, d_dy_q, d_dz_q;
  // E: perpendicular components and P2
  logic signed [44:0] e_rx, e_ry, e_rz;
  logic signed [63:0] e_v;
  logic signed [31:0] e_px_q, e_py_q, e_pz_q;
  logic signed [63:0] e_p2_q;
  logic signed [57:0] e_par_q;
  logic signed [33:0] e_c_q;
  // F: squares
  logic signed [63:0] f_sx_q, f_sy_q, f_sz_q;
  logic signed [63:0] f_p2_q;
  logic signed [57:0] f_par_q;
  logic signed [33:0] f_c_q;
  // G: perpendicular sum
  term_t              g_term_q;

  always_comb begin
    c_l  = 43'(b_lx_q) + 43'(b_ly_q) + 43'(b_lz_q) + 43'sd8192;
    e_rx = d_ox_q + 45'sd8192;
    e_ry = d_oy_q + 45'sd8192;
    e_rz = d_oz_q + 45'sd8192;
    e_v  = d_cc_q + (d_cc_q <<< 1) - (64'sd1 <<< 56) + (64'sd1 <<< 28);
  end

  always_ff @(posedge clk_i) begin
    a_dx_q <= 25'(old_i.pos.x) - 25'(new_pos_i.x);
    a_dy_q <= 25'(old_i.pos.y) - 25'(new_pos_i.y);
    a_dz_q <= 25'(old_i.pos.z) - 25'(new_pos_i.z);
    a_uo_q <= old_i.ori;

    b_lx_q <= a_dx_q * new_ori_i.x;
    b_ly_q <= a_dy_q * new_ori_i.y;
    b_lz_q <= a_dz_q * new_ori_i.z;
    b_cx_q <= a_uo_q.x * new_ori_i.x;
    b_cy_q <= a_uo_q.y * new_ori_i.y;
    b_cz_q <= a_uo_q.z * new_ori_i.z;
    b_dx_q <= a_dx_q;
    b_dy_q <= a_dy_q;
    b_dz_q <= a_dz_q;

    c_lr_q <= c_l[42:14];
    c_c_q  <= 34'(b_cx_q) + 34'(b_cy_q) + 34'(b_cz_q);
    c_dx_q <= b_dx_q;
    c_dy_q <= b_dy_q;
    c_dz_q <= b_dz_q;

    d_ox_q  <= c_lr_q * new_ori_i.x;
    d_oy_q  <= c_lr_q * new_ori_i.y;
    d_oz_q  <= c_lr_q * new_ori_i.z;
    d_par_q <= c_lr_q * c_lr_q;
    d_cc_q  <= 64'(c_c_q) * 64'(c_c_q);
    d_c_q   <= c_c_q;
    d_dx_q  <= c_dx_q;
    d_dy_q  <= c_dy_q;
    d_dz_q  <= c_dz_q;

    e_px_q  <= 32'(d_dx_q) - 32'(e_rx >>> 14);
    e_py_q  <= 32'(d_dy_q) - 32'(e_ry >>> 14);
    e_pz_q  <= 32'(d_dz_q) - 32'(e_rz >>> 14);
    e_p2_q  <= e_v >>> 29;
    e_par_q <= d_par_q;
    e_c_q   <= d_c_q;

    f_sx_q  <= e_px_q * e_px_q;
    f_sy_q  <= e_py_q * e_py_q;
    f_sz_q  <= e_pz_q * e_pz_q;
    f_p2_q  <= e_p2_q;
    f_par_q <= e_par_q;
    f_c_q   <= e_c_q;

    g_term_q.perp <= 64'(f_sx_q) + 64'(f_sy_q) + 64'(f_sz_q);
    g_term_q.par  <= 64'(f_par_q);
    g_term_q.c    <= 64'(f_c_q);
    g_term_q.p2   <= f_p2_q;
  end

  assign term_vld_o = vld_q[NSTG-1];
  assign term_lag_o = lag_q[NSTG-1];
  assign term_o     = g_term_q;

endmodule

/* rtl/omsd_acc_bank.sv */
// Per-lag saturating accumulator memory with read-modify-write and host read.
module omsd_acc_bank import omsd_pkg::*; #(
  parameter int unsigned MAX_LAGS = MAX_LAGS_DEF,
  parameter int unsigned AW       = $clog2(MAX_LAGS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          term_vld_i,
  input  logic [AW-1:0] term_lag_i,
  input  term_t         term_i,
  input  logic [AW-1:0] rd_addr_i,
  output acc_t          rd_data_o
);

  acc_t          mem [MAX_LAGS];
  logic          ent_vld_q [MAX_LAGS];
  acc_t          rdata_q;
  logic          rvld_q;
  logic [AW-1:0] raddr_q;
  logic [AW-1:0] raddr;
  acc_t          cur;
  acc_t          upd;
  logic          h_vld_q;
  logic [AW-1:0] h_lag_q;
  term_t         h_term_q;

  // pipeline term owns the port while walking; host reads happen only when idle
  assign raddr = term_vld_i ? term_lag_i : rd_addr_i;

  always_ff @(posedge clk_i) begin
    rdata_q  <= mem[raddr];
    raddr_q  <= raddr;
    rvld_q   <= ent_vld_q[raddr];
    h_lag_q  <= term_lag_i;
    h_term_q <= term_i;
    if (h_vld_q) begin
      mem[h_lag_q] <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
      for (int i = 0; i < MAX_LAGS; i++) ent_vld_q[i] <= 1'b0;
    end else begin
      h_vld_q <= term_vld_i;
      if (h_vld_q) begin
        ent_vld_q[h_lag_q] <= 1'b1;
      end
    end
  end

  // unwritten entries read as their reset value
  always_comb begin
    if (rvld_q) begin
      cur = rdata_q;
    end else begin
      cur      = '0;
      cur.l1   = (raddr_q == '0) ? ONE_Q28 : '0;
      cur.l2   = (raddr_q == '0) ? ONE_Q28 : '0;
    end
  end

  always_comb begin
    upd.par  = uadd_sat(cur.par, h_term_q.par);
    upd.perp = uadd_sat(cur.perp, h_term_q.perp);
    upd.l1   = sadd_sat(cur.l1, h_term_q.c);
    upd.l2   = sadd_sat(cur.l2, h_term_q.p2);
  end

  assign rd_data_o = cur;

endmodule

/* rtl/orientational_msd_correlator.sv */
// Top level of the orientational MSD correlator: control, registers and result port.
//
//  channel  direction  handshake                   payload
//  -------  ---------  --------------------------  ---------------------------------------
//  item     in         start & !busy               kind_i, particle_index_i, end_of_tick_i,
//                                                  pos_*_i, orient_*_i, lag_i
//  result   out        result_valid_o, one cycle   parallel_sum_o, perpendicular_sum_o,
//                                                  legendre1_sum_o, legendre2_sum_o,
//                                                  ticks_taken_o
//  config   in         cfg_we_i, no wait           cfg_idx_i, cfg_wdata_i
//
// Sequencing: a sample whose particle ring is full walks lags 1..lag_count-1 at one history
// read per cycle, then drains the multiply/accumulate pipeline, with busy high through the
// walk and drain states. Other samples leave the block idle. A read transaction keeps
// busy for one cycle and shows its result from registers loaded in the read state.
// Reset clears all control state; the accumulators read as their reset values through
// per-lag valid bits, and history entries are undefined until written.
// The receiver cannot stall: result_valid_o is a single-cycle strobe.
module orientational_msd_correlator import omsd_pkg::*; #(
  parameter int unsigned MAX_LAGS      = MAX_LAGS_DEF,
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                kind_i,
  input  logic [7:0]          particle_index_i,
  input  logic                end_of_tick_i,
  input  logic signed [23:0]  pos_x_i,
  input  logic signed [23:0]  pos_y_i,
  input  logic signed [23:0]  pos_z_i,
  input  logic signed [15:0]  orient_x_i,
  input  logic signed [15:0]  orient_y_i,
  input  logic signed [15:0]  orient_z_i,
  input  logic [5:0]          lag_i,
  output logic                result_valid_o,
  output logic [62:0]         parallel_sum_o,
  output logic [62:0]         perpendicular_sum_o,
  output logic signed [63:0]  legendre1_sum_o,
  output logic signed [63:0]  legendre2_sum_o,
  output logic [31:0]         ticks_taken_o
);

  localparam int unsigned LAG_W   = $clog2(MAX_LAGS + 1);   // holds lag_count itself
  localparam int unsigned SLOT_W  = $clog2(MAX_LAGS);       // ring slot / lag index
  localparam int unsigned HDEPTH  = MAX_LAGS * MAX_PARTICLES;
  localparam int unsigned HAW     = $clog2(HDEPTH);
  localparam int unsigned DRN_W   = $clog2(DRAIN_CYCLES);
  localparam int unsigned LC_RST  = (LAG_COUNT_RST > MAX_LAGS) ? MAX_LAGS : LAG_COUNT_RST;
  localparam int unsigned PC_RST  = (PART_COUNT_RST > MAX_PARTICLES) ? MAX_PARTICLES
                                                                      : PART_COUNT_RST;

  omsd_state_e         state_q, state_d;
  logic [LAG_W-1:0]    lag_count_q;
  logic [CFG_W-1:0]    part_count_q;
  logic [SLOT_W-1:0]   head_q;
  logic [LAG_W-1:0]    fill_q;
  logic [31:0]         tick_q;
  logic [7:0]          pidx_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SLOT_W-1:0]   step_q;
  logic [DRN_W-1:0]    drain_q;
  pos_t                new_pos_q;
  orient_t             new_ori_q;
  logic                lag_ok_q;
  logic [SLOT_W-1:0]   rd_lag_q;
  logic                iss_vld_q;
  logic [SLOT_W-1:0]   iss_lag_q;
  acc_t                res_q;
  logic [31:0]         res_ticks_q;
  logic                res_vld_q;

  logic                accept, is_read, is_sample, p_ok, ready, last_step;
  logic                walk_issue, hist_we;
  logic [6:0]          cfg_lag;
  logic [LAG_W-1:0]    lag_new;
  logic [CFG_W-1:0]    pc_new;
  logic [SLOT_W-1:0]   first_slot, prev_slot;
  logic [HAW-1:0]      hist_waddr, hist_raddr;
  hist_t               hist_wdata, hist_rdata;
  logic                term_vld;
  logic [SLOT_W-1:0]   term_lag;
  term_t               term;
  acc_t                acc_rd;

  assign accept    = start && !busy;
  assign is_read   = (kind_i == KIND_READ);
  assign is_sample = (kind_i == KIND_SAMPLE);
  // particle must be inside both the configured and the built population
  assign p_ok      = (9'(particle_index_i) < part_count_q) &&
                     (32'(particle_index_i) < MAX_PARTICLES);
  // tick accumulates once the ring holds lag_count samples including this one
  assign ready     = (32'(fill_q) + 32'd1) >= 32'(lag_count_q);
  assign last_step = (LAG_W'(step_q) == lag_count_q - LAG_W'(1));

  // ring slots walk backward from the newest one, wrapping at lag_count
  assign first_slot = (head_q == '0) ? SLOT_W'(lag_count_q - LAG_W'(1)) : head_q - SLOT_W'(1);
  assign prev_slot  = (slot_q == '0) ? SLOT_W'(lag_count_q - LAG_W'(1)) : slot_q - SLOT_W'(1);

  // config value clamping
  assign cfg_lag = cfg_wdata_i[6:0];
  always_comb begin
    if (cfg_lag < 7'd2) begin
      lag_new = LAG_W'(2);
    end else if (32'(cfg_lag) > MAX_LAGS) begin
      lag_new = LAG_W'(MAX_LAGS);
    end else begin
      lag_new = LAG_W'(cfg_lag);
    end
    if (cfg_wdata_i == '0) begin
      pc_new = CFG_W'(1);
    end else if (32'(cfg_wdata_i) > MAX_PARTICLES) begin
      pc_new = CFG_W'(MAX_PARTICLES);
    end else begin
      pc_new = cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_read) begin
          state_d = ST_READ;
        end else if (accept && is_sample && p_ok && ready) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK:  if (last_step) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q == '0) state_d = ST_IDLE;
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = 1'b1;
    walk_issue = 1'b0;
    case (state_q)
      ST_IDLE:  busy = 1'b0;
      ST_WALK:  walk_issue = 1'b1;
      ST_DRAIN: busy = 1'b1;
      ST_READ:  busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  assign hist_we    = accept && is_sample && p_ok;
  assign hist_waddr = HAW'(32'(particle_index_i) * MAX_LAGS + 32'(head_q));
  assign hist_raddr = HAW'(32'(pidx_q) * MAX_LAGS + 32'(slot_q));
  assign hist_wdata = '{pos: '{x: pos_x_i, y: pos_y_i, z: pos_z_i},
                        ori: '{x: orient_x_i, y: orient_y_i, z: orient_z_i}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lag_count_q  <= LAG_W'(LC_RST);
      part_count_q <= CFG_W'(PC_RST);
      head_q       <= '0;
      fill_q       <= '0;
      tick_q       <= '0;
      step_q       <= '0;
      slot_q       <= '0;
      drain_q      <= '0;
      iss_vld_q    <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_vld_q <= walk_issue;
      res_vld_q <= (state_q == ST_READ);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LAG_COUNT: begin
            lag_count_q <= lag_new;
            head_q      <= '0;
            fill_q      <= '0;
          end
          REG_PART_COUNT: part_count_q <= pc_new;
          default: ;
        endcase
      end else if (accept && is_sample && end_of_tick_i) begin
        if (ready && tick_q != '1) begin
          tick_q <= tick_q + 32'd1;
        end
        head_q <= (LAG_W'(head_q) + LAG_W'(1) == lag_count_q) ? '0 : head_q + SLOT_W'(1);
        if (fill_q < lag_count_q) begin
          fill_q <= fill_q + LAG_W'(1);
        end
      end

      if (state_q == ST_IDLE) begin
        step_q <= SLOT_W'(1);
        slot_q <= first_slot;
      end else if (walk_issue) begin
        step_q <= step_q + SLOT_W'(1);
        slot_q <= prev_slot;
      end

      if (state_q == ST_WALK) begin
        drain_q <= DRN_W'(DRAIN_CYCLES - 1);
      end else if (drain_q != '0) begin
        drain_q <= drain_q - DRN_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pidx_q    <= particle_index_i;
      new_pos_q <= hist_wdata.pos;
      new_ori_q <= hist_wdata.ori;
      lag_ok_q  <= 32'(lag_i) < MAX_LAGS;
      rd_lag_q  <= SLOT_W'(lag_i);
    end
    iss_lag_q <= step_q;
    if (state_q == ST_READ) begin
      res_q       <= lag_ok_q ? acc_rd : '0;
      res_ticks_q <= tick_q;
    end
  end

  omsd_hist_mem #(
    .DEPTH (HDEPTH),
    .AW    (HAW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  omsd_lag_math #(
    .LAG_AW (SLOT_W)
  ) u_math (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (iss_vld_q),
    .in_lag_i   (iss_lag_q),
    .old_i      (hist_rdata),
    .new_pos_i  (new_pos_q),
    .new_ori_i  (new_ori_q),
    .term_vld_o (term_vld),
    .term_lag_o (term_lag),
    .term_o     (term)
  );

  // read address is lag_i while a transaction is accepted, else the lag captured at acceptance
  omsd_acc_bank #(
    .MAX_LAGS (MAX_LAGS),
    .AW       (SLOT_W)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .term_vld_i (term_vld),
    .term_lag_i (term_lag),
    .term_i     (term),
    .rd_addr_i  (accept ? SLOT_W'(lag_i) : rd_lag_q),
    .rd_data_o  (acc_rd)
  );

  assign result_valid_o      = res_vld_q;
  assign parallel_sum_o      = res_q.par;
  assign perpendicular_sum_o = res_q.perp;
  assign legendre1_sum_o     = res_q.l1;
  assign legendre2_sum_o     = res_q.l2;
  assign ticks_taken_o       = res_ticks_q;

endmodule

/* rtl/omsd_checker.sv */
// Port-level checks for the correlator, bound to the top level.
module omsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic kind_i,
  input logic result_valid_o
);

  logic rd_acc;
  assign rd_acc = start && !busy && kind_i;

  a_rd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> busy) else $error("read transaction did not hold busy");

  a_rd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> ##1 result_valid_o) else $error("read result missing");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(rd_acc, 2)) else $error("result without read transaction");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

endmodule

bind orientational_msd_correlator omsd_checker u_omsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .result_valid_o (result_valid_o)
);

/* tb/tb_top.sv */
// Testbench for orientational_msd_correlator: directed table, then random ticks against a predictor.
//
// Stimulus is organized in ticks. Every in-range particle is sampled once per tick
// (random order, occasional resamples), with read transactions and out-of-range samples
// mixed in as noise. Because every tick covers every particle, a history walk never
// touches a ring slot that was not written. Configuration changes happen only with the
// block idle, between phases; each phase restarts ring filling.
module tb_top;
  import omsd_pkg::*;

  localparam int unsigned HIST_DEPTH = MAX_PARTICLES_DEF * MAX_LAGS_DEF;
  localparam longint unsigned USAT64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 3000000;

  // one transaction on the item channel
  typedef struct {
    logic               kind;
    logic [7:0]         pidx;
    logic               eot;
    logic signed [23:0] px, py, pz;
    logic signed [15:0] ox, oy, oz;
    logic [5:0]         lag;
  } item_t;

  // accumulator snapshot for one lag, as the read port returns it
  typedef struct {
    logic [62:0]        par;
    logic [62:0]        perp;
    logic signed [63:0] l1;
    logic signed [63:0] l2;
    logic [31:0]        ticks;
  } lag_sums_t;

  // directed row: optional hand-written expectation
  typedef struct {
    item_t     it;
    bit        typed;
    lag_sums_t sums;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               kind_i;
  logic [7:0]         particle_index_i;
  logic               end_of_tick_i;
  logic signed [23:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [15:0] orient_x_i, orient_y_i, orient_z_i;
  logic [5:0]         lag_i;
  logic               result_valid_o;
  logic [62:0]        parallel_sum_o;
  logic [62:0]        perpendicular_sum_o;
  logic signed [63:0] legendre1_sum_o;
  logic signed [63:0] legendre2_sum_o;
  logic [31:0]        ticks_taken_o;

  orientational_msd_correlator uut (
    .clk_i, .rst_ni, .start, .busy,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .kind_i, .particle_index_i, .end_of_tick_i,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .orient_x_i, .orient_y_i, .orient_z_i, .lag_i,
    .result_valid_o, .parallel_sum_o, .perpendicular_sum_o,
    .legendre1_sum_o, .legendre2_sum_o, .ticks_taken_o
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: mirror of the correlator's histories, ring pointers and sums
  // ---------------------------------------------------------------------------
  int             hist_x[HIST_DEPTH], hist_y[HIST_DEPTH], hist_z[HIST_DEPTH];
  int             dir_x[HIST_DEPTH], dir_y[HIST_DEPTH], dir_z[HIST_DEPTH];
  int unsigned    lags_in_use, particles_in_use;
  int unsigned    ring_pos, ticks_filled;
  int unsigned    tick_tally;
  longint unsigned par_sum[MAX_LAGS_DEF], perp_sum[MAX_LAGS_DEF];
  longint          p1_sum[MAX_LAGS_DEF], p2_sum[MAX_LAGS_DEF];

  lag_sums_t pending_reads[$];
  int        errors = 0;
  int        items_sent = 0;
  int        reads_checked = 0;
  int        walks_done = 0;
  longint    cycles = 0;

  function automatic longint unsigned sum_unsigned_sat(longint unsigned a,
                                                       longint unsigned b);
    longint unsigned s;
    s = a + b;
    if (s < a || s > USAT64) return USAT64;
    return s;
  endfunction

  function automatic longint sum_signed_sat(longint a, longint b);
    if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b < 0 && a < 64'sh8000_0000_0000_0000 - b) return 64'sh8000_0000_0000_0000;
    return a + b;
  endfunction

  function automatic void reset_sums();
    lags_in_use = LAG_COUNT_RST;
    particles_in_use = PART_COUNT_RST;
    ring_pos = 0;
    ticks_filled = 0;
    tick_tally = 0;
    for (int i = 0; i < MAX_LAGS_DEF; i++) begin
      par_sum[i] = 0;
      perp_sum[i] = 0;
      p1_sum[i] = 0;
      p2_sum[i] = 0;
    end
    p1_sum[0] = ONE_Q28;
    p2_sum[0] = ONE_Q28;
  endfunction

  function automatic void apply_register(logic idx, logic [CFG_W-1:0] data);
    int unsigned v;
    if (idx == REG_LAG_COUNT) begin
      v = data[6:0];
      if (v < 2) v = 2;
      if (v > MAX_LAGS_DEF) v = MAX_LAGS_DEF;
      lags_in_use = v;
      ring_pos = 0;
      ticks_filled = 0;
    end else begin
      v = data;
      if (v < 1) v = 1;
      if (v > MAX_PARTICLES_DEF) v = MAX_PARTICLES_DEF;
      particles_in_use = v;
    end
  endfunction

  // newest sample of one particle against each older ring entry
  function automatic void correlate_particle(int unsigned base);
    int unsigned newest, older;
    longint nx, ny, nz, ux, uy, uz, dx, dy, dz, proj, projr, qx, qy, qz, cosv, sq3, leg2;
    longint unsigned perp;
    newest = base + ring_pos;
    nx = hist_x[newest]; ny = hist_y[newest]; nz = hist_z[newest];
    ux = dir_x[newest];  uy = dir_y[newest];  uz = dir_z[newest];
    for (int unsigned s = 1; s < lags_in_use; s++) begin
      older = base + (ring_pos + lags_in_use - s) % lags_in_use;
      dx = longint'(hist_x[older]) - nx;
      dy = longint'(hist_y[older]) - ny;
      dz = longint'(hist_z[older]) - nz;
      proj = dx * ux + dy * uy + dz * uz;
      projr = (proj + 64'sd8192) >>> 14;
      qx = dx - ((projr * ux + 64'sd8192) >>> 14);
      qy = dy - ((projr * uy + 64'sd8192) >>> 14);
      qz = dz - ((projr * uz + 64'sd8192) >>> 14);
      perp = longint'(qx * qx) + longint'(qy * qy) + longint'(qz * qz);
      cosv = longint'(dir_x[older]) * ux + longint'(dir_y[older]) * uy
           + longint'(dir_z[older]) * uz;
      // 64-bit wrapping arithmetic, as the datapath computes it
      sq3 = 64'sd3 * (cosv * cosv) - (64'sd1 <<< 56);
      leg2 = (sq3 + (64'sd1 <<< 28)) >>> 29;
      par_sum[s] = sum_unsigned_sat(par_sum[s], projr * projr);
      perp_sum[s] = sum_unsigned_sat(perp_sum[s], perp);
      p1_sum[s] = sum_signed_sat(p1_sum[s], cosv);
      p2_sum[s] = sum_signed_sat(p2_sum[s], leg2);
    end
    walks_done++;
  endfunction

  // advance predictor by one accepted transaction; reads push an expectation
  function automatic void predict_item(item_t it);
    lag_sums_t e;
    int unsigned p, slot;
    bit ready;
    if (it.kind == KIND_READ) begin
      e.par = par_sum[it.lag][62:0];
      e.perp = perp_sum[it.lag][62:0];
      e.l1 = p1_sum[it.lag];
      e.l2 = p2_sum[it.lag];
      e.ticks = tick_tally;
      pending_reads.push_back(e);
      return;
    end
    p = it.pidx;
    ready = (ticks_filled + 1 >= lags_in_use);
    if (p < particles_in_use) begin
      slot = p * MAX_LAGS_DEF + ring_pos;
      hist_x[slot] = it.px; hist_y[slot] = it.py; hist_z[slot] = it.pz;
      dir_x[slot] = it.ox;  dir_y[slot] = it.oy;  dir_z[slot] = it.oz;
      if (ready) correlate_particle(p * MAX_LAGS_DEF);
    end
    if (it.eot) begin
      if (ready && tick_tally != 32'hFFFF_FFFF) tick_tally++;
      ring_pos = (ring_pos + 1) % lags_in_use;
      if (ticks_filled < lags_in_use) ticks_filled++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the block cannot be stalled, so sample every strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lag_sums_t e;
    cycles <= cycles + 1;
    if (result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        e = pending_reads.pop_front();
        reads_checked++;
        if (parallel_sum_o !== e.par) begin
          $display("%0t: parallel_sum exp %0d got %0d", $time, e.par, parallel_sum_o);
          errors++;
        end
        if (perpendicular_sum_o !== e.perp) begin
          $display("%0t: perpendicular_sum exp %0d got %0d", $time, e.perp,
                   perpendicular_sum_o);
          errors++;
        end
        if (legendre1_sum_o !== e.l1) begin
          $display("%0t: legendre1_sum exp %0d got %0d", $time, e.l1, legendre1_sum_o);
          errors++;
        end
        if (legendre2_sum_o !== e.l2) begin
          $display("%0t: legendre2_sum exp %0d got %0d", $time, e.l2, legendre2_sum_o);
          errors++;
        end
        if (ticks_taken_o !== e.ticks) begin
          $display("%0t: ticks_taken exp %0d got %0d", $time, e.ticks, ticks_taken_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_reads.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------
  // drive one transaction, hold it until accepted; start stays high afterwards
  task automatic send_item(item_t it);
    start <= 1'b1;
    kind_i <= it.kind;
    particle_index_i <= it.pidx;
    end_of_tick_i <= it.eot;
    pos_x_i <= it.px; pos_y_i <= it.py; pos_z_i <= it.pz;
    orient_x_i <= it.ox; orient_y_i <= it.oy; orient_z_i <= it.oz;
    lag_i <= it.lag;
    do @(posedge clk_i); while (busy);
    predict_item(it);
    items_sent++;
  endtask

  // random sender gap: mostly none, some short, a few long
  task automatic sender_gap();
    int unsigned r, n;
    r = $urandom_range(99);
    if (r < 60) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // stop sending until every read has come back and the walk pipeline has drained
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0 || busy) @(posedge clk_i);
    repeat (MAX_LAGS_DEF + DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t random_fields();
    item_t it;
    it.kind = KIND_SAMPLE;
    it.pidx = $urandom;
    it.eot = 1'b0;
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.ox = $signed($urandom_range(32768)) - 16384;
    it.oy = $signed($urandom_range(32768)) - 16384;
    it.oz = $signed($urandom_range(32768)) - 16384;
    it.lag = $urandom;
    return it;
  endfunction

  function automatic item_t read_item();
    item_t it;
    it = random_fields();
    it.kind = KIND_READ;
    it.eot = $urandom;
    // favor lags inside the configured window
    if ($urandom_range(3) != 0) it.lag = $urandom_range(lags_in_use - 1);
    return it;
  endfunction

  // sample for a particle that is not configured; it only may end the tick
  function automatic item_t stray_item(bit eot);
    item_t it;
    it = random_fields();
    it.pidx = $urandom_range(MAX_PARTICLES_DEF - 1, particles_in_use);
    it.eot = eot;
    return it;
  endfunction

  // optional noise ahead of a sample
  task automatic maybe_noise();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) begin
      send_item(read_item());
      sender_gap();
    end else if (r < 22 && particles_in_use < MAX_PARTICLES_DEF) begin
      send_item(stray_item(1'b0));
      sender_gap();
    end
  endtask

  // one full tick: every configured particle sampled, in random order
  task automatic run_tick();
    int unsigned order[$];
    int unsigned j, tmp;
    bit stray_end;
    item_t it;
    for (int unsigned i = 0; i < particles_in_use; i++) order.push_back(i);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    stray_end = (particles_in_use < MAX_PARTICLES_DEF) && ($urandom_range(4) == 0);
    foreach (order[k]) begin
      maybe_noise();
      it = random_fields();
      it.pidx = order[k];
      // occasional resample of the same particle within the tick
      if ($urandom_range(19) == 0) begin
        send_item(it);
        sender_gap();
        it = random_fields();
        it.pidx = order[k];
      end
      it.eot = (k == order.size() - 1) && !stray_end;
      send_item(it);
      sender_gap();
    end
    if (stray_end) begin
      send_item(stray_item(1'b1));
      sender_gap();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, run with reset configuration (lag_count 50, 256 particles)
  // ---------------------------------------------------------------------------
  function automatic row_t make_row(logic kind, logic [7:0] pidx, logic eot,
                                    logic signed [23:0] pv, logic signed [15:0] ov,
                                    logic [5:0] lag);
    row_t r;
    r.it.kind = kind; r.it.pidx = pidx; r.it.eot = eot;
    r.it.px = pv; r.it.py = -pv; r.it.pz = pv;
    r.it.ox = ov; r.it.oy = -ov; r.it.oz = ov;
    r.it.lag = lag;
    r.typed = 1'b0;
    r.sums = '{default: '0};
    return r;
  endfunction

  function automatic row_t typed_read(logic [5:0] lag, logic signed [63:0] legendre);
    row_t r;
    r = make_row(KIND_READ, 8'hFF, 1'b1, 24'sh7FFFFF, -16'sd16384, lag);
    r.typed = 1'b1;
    r.sums.l1 = legendre;
    r.sums.l2 = legendre;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    lag_sums_t typed_sums;
    int unsigned phase_lag[6] = '{2, 127, 5, 1, 16, 3};
    int unsigned phase_part[6] = '{1, 0, 3, 511, 7, 2};
    int unsigned phase_items[6] = '{200, 260, 320, 290, 280, 200};
    int unsigned phase_end;

    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_LAG_COUNT;
    cfg_wdata_i = '0;
    kind_i = KIND_SAMPLE;
    particle_index_i = '0;
    end_of_tick_i = 1'b0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    orient_x_i = '0; orient_y_i = '0; orient_z_i = '0;
    lag_i = '0;
    reset_sums();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: P1/P2 at lag 0 read 1.0, everything else zero
    rows.push_back(typed_read(6'd0, ONE_Q28));
    rows.push_back(typed_read(6'd1, 64'sd0));
    rows.push_back(typed_read(6'd63, 64'sd0));
    rows.push_back(typed_read(6'd49, 64'sd0));
    // samples at field extremes, far from a full ring so nothing accumulates
    rows.push_back(make_row(KIND_SAMPLE, 8'd0, 1'b0, 24'sh7FFFFF, 16'sd16384, 6'd0));
    rows.push_back(make_row(KIND_SAMPLE, 8'd255, 1'b0, -24'sh800000, -16'sd16384, 6'd63));
    rows.push_back(make_row(KIND_SAMPLE, 8'd128, 1'b1, 24'sd0, 16'sd0, 6'd21));
    rows.push_back(make_row(KIND_SAMPLE, 8'd1, 1'b1, -24'sd1, 16'sd1, 6'd42));
    rows.push_back(make_row(KIND_READ, 8'd7, 1'b0, 24'sd4096, 16'sd8192, 6'd2));
    rows.push_back(make_row(KIND_SAMPLE, 8'd127, 1'b1, 24'sh555555, -16'sd1, 6'd0));
    rows.push_back(typed_read(6'd0, ONE_Q28));
    rows.push_back(make_row(KIND_READ, 8'd0, 1'b1, 24'sd0, 16'sd0, 6'd50));

    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].typed) begin
        typed_sums = pending_reads[$];
        if (typed_sums.l1 !== rows[i].sums.l1 || typed_sums.l2 !== rows[i].sums.l2 ||
            typed_sums.par !== 63'd0 || typed_sums.perp !== 63'd0 ||
            typed_sums.ticks !== 32'd0) begin
          $display("%0t: reset value row %0d: predicted state disagrees", $time, i);
          errors++;
        end
        pending_reads[$] = rows[i].sums;
      end
      sender_gap();
    end

    // random phases; register writes only with the block quiet. Out-of-range
    // writes exercise the clamps (lag 127 -> 64, 1 -> 2; particles 0 -> 1, 511 -> 256).
    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      write_register(REG_PART_COUNT, phase_part[ph]);
      write_register(REG_LAG_COUNT, phase_lag[ph]);
      phase_end = items_sent + phase_items[ph];
      while (items_sent < phase_end) run_tick();
      send_item(read_item());
    end

    drain_block();
    $display("Sent %0d transactions over 6 register settings; %0d reads checked,", items_sent,
             reads_checked);
    $display("%0d history walks predicted, %0d ticks accumulated.", walks_done, tick_tally);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/omsd_pkg.sv
rtl/omsd_hist_mem.sv
rtl/omsd_lag_math.sv
rtl/omsd_acc_bank.sv
rtl/orientational_msd_correlator.sv
rtl/omsd_checker.sv
tb/tb_top.sv
